// ----- hdl/cicmd_pkg.sv -----
// ----------------------------------------------------------------------------
// cicmd_pkg
// Shared types, constants and helpers for the cloud-in-cell mass deposit
// block: item and result structs, grid geometry and the grid store request.
// ----------------------------------------------------------------------------
package cicmd_pkg;

    // Grid geometry
    localparam int GRID_SIDE  = 32;
    localparam int IDX_W      = $clog2(GRID_SIDE);
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Field widths
    localparam int POS_W      = 28;
    localparam int CPL_W      = 24;
    localparam int CIDX_W     = 5;
    localparam int CELL_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = FRAC_W + 1;
    localparam int GINT_W     = POS_W + CPL_W - 2 * FRAC_W;

    // Shared multiplier: scaling is POS_W x CPL_W, weights are 33 x WGT_W
    localparam int MUL_A_W    = 2 * FRAC_W + 1;
    localparam int MUL_B_W    = CPL_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int W3_W       = 3 * FRAC_W + 1;

    localparam logic [WGT_W-1:0] ONE_FIX = WGT_W'(1) << FRAC_W;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_CELLS_PER_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_USE_CLOUD_IN_CELL = 1'd1;
    localparam logic [CPL_W-1:0] CPL_RESET = 24'd1263316;

    // Opcodes
    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [CIDX_W-1:0] cell_x;
        logic [CIDX_W-1:0] cell_y;
        logic [CIDX_W-1:0] cell_z;
        logic              last_item;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic              out_of_box;
        logic              saturated;
        logic              batch_done;
    } t_result;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } t_grid_req;

    function automatic logic [ADDR_W-1:0] flat_index(input logic [IDX_W-1:0] x,
                                                      input logic [IDX_W-1:0] y,
                                                      input logic [IDX_W-1:0] z);
        logic [ADDR_W-1:0] row;
        row = ADDR_W'(x) * ADDR_W'(GRID_SIDE) + ADDR_W'(y);
        return row * ADDR_W'(GRID_SIDE) + ADDR_W'(z);
    endfunction

endpackage

// ----- hdl/cicmd_grid.sv -----
// ----------------------------------------------------------------------------
// cicmd_grid
// Density grid store: one port, registered read data, and a clearing sweep
// that zeroes every cell after reset, one cell per cycle.
// ----------------------------------------------------------------------------
module cicmd_grid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cicmd_pkg::t_grid_req          i_req,
    output logic [cicmd_pkg::CELL_W-1:0]  o_rdata,
    output logic                          o_clearing
);

    logic [cicmd_pkg::CELL_W-1:0] r_mem [cicmd_pkg::CELL_COUNT];
    logic [cicmd_pkg::CELL_W-1:0] r_rdata;
    logic [cicmd_pkg::ADDR_W-1:0] r_clr_addr;
    logic [cicmd_pkg::ADDR_W-1:0] n_clr_addr;
    logic                         r_clearing;
    logic                         n_clearing;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clearing = r_clearing;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + cicmd_pkg::ADDR_W'(1);
            if (r_clr_addr == cicmd_pkg::ADDR_W'(cicmd_pkg::CELL_COUNT - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clearing <= 1'b1;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_clearing <= n_clearing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

// ----- hdl/cloud_in_cell_mass_deposit.sv -----
// ----------------------------------------------------------------------------
// cloud_in_cell_mass_deposit
// Deposits particles onto a periodic cubic density grid (cloud-in-cell or
// nearest-grid-point) and reads back single cells.
// ----------------------------------------------------------------------------
// After reset the grid is swept to zero, one cell per cycle: busy stays high
// until the sweep has finished, and no item is taken meanwhile. An item is
// taken when start is high and busy is low; its result appears on o_result
// with o_done high for exactly one cycle and must be captured then, as the
// receiver cannot stall the block. A deposit uses one shared multiplier
// three times to scale the position and, in cloud-in-cell mode, twice per
// corner for the trilinear weight, and the single grid memory port does one
// read-modify-write per corner. Configuration is to be written by the user
// only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cloud_in_cell_mass_deposit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cicmd_pkg::t_in_item                 i_item,
    output logic                                o_done,
    output cicmd_pkg::t_result                  o_result,
    input  logic                                i_cfg_we,
    input  logic [cicmd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [cicmd_pkg::CPL_W-1:0]         i_cfg_wdata
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_RREQ  = 10'b00_0000_0100,
        S_RRSP  = 10'b00_0000_1000,
        S_MUL   = 10'b00_0001_0000,
        S_GRAB  = 10'b00_0010_0000,
        S_MA    = 10'b00_0100_0000,
        S_MB    = 10'b00_1000_0000,
        S_WT    = 10'b01_0000_0000,
        S_UPD   = 10'b10_0000_0000
    } t_state;

    t_state                          r_state, n_state;
    logic [cicmd_pkg::CPL_W-1:0]     r_cpl, n_cpl;
    logic                            r_use_cic, n_use_cic;
    logic                            r_done, n_done;
    cicmd_pkg::t_result              r_result, n_result;
    cicmd_pkg::t_in_item             r_item, n_item;
    logic [1:0]                      r_axis, n_axis;
    logic [2:0]                      r_corner, n_corner;
    logic [cicmd_pkg::IDX_W-1:0]     r_lo [3];
    logic [cicmd_pkg::IDX_W-1:0]     n_lo [3];
    logic [cicmd_pkg::FRAC_W-1:0]    r_frac [3];
    logic [cicmd_pkg::FRAC_W-1:0]    n_frac [3];
    logic [cicmd_pkg::PROD_W-1:0]    r_prod;
    logic [cicmd_pkg::WGT_W-1:0]     r_weight, n_weight;
    logic [cicmd_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic                            r_sat, n_sat;

    logic [cicmd_pkg::MUL_A_W-1:0]   mul_a;
    logic [cicmd_pkg::MUL_B_W-1:0]   mul_b;
    logic [cicmd_pkg::PROD_W-1:0]    prod;
    logic [cicmd_pkg::WGT_W-1:0]     wsel [3];
    logic [cicmd_pkg::IDX_W-1:0]     csel [3];
    logic [cicmd_pkg::POS_W-1:0]     axis_pos;
    logic [cicmd_pkg::GINT_W-1:0]    g_int;
    logic [cicmd_pkg::W3_W-1:0]      w_round;
    logic [cicmd_pkg::CELL_W:0]      upd_sum;
    logic                            rd_ok;
    logic [cicmd_pkg::CELL_W-1:0]    grid_rdata;
    logic                            grid_clearing;
    cicmd_pkg::t_grid_req            grid_req;

    cicmd_grid u_grid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (grid_req),
        .o_rdata    (grid_rdata),
        .o_clearing (grid_clearing)
    );

    // Per-axis weight and cell index for the current corner
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_corner[a]) begin
                wsel[a] = {1'b0, r_frac[a]};
                if (r_lo[a] == cicmd_pkg::IDX_W'(cicmd_pkg::GRID_SIDE - 1)) begin
                    csel[a] = '0;
                end else begin
                    csel[a] = r_lo[a] + cicmd_pkg::IDX_W'(1);
                end
            end else begin
                wsel[a] = cicmd_pkg::ONE_FIX - {1'b0, r_frac[a]};
                csel[a] = r_lo[a];
            end
        end
    end

    always_comb begin
        case (r_axis)
            2'd0:    axis_pos = r_item.pos_x;
            2'd1:    axis_pos = r_item.pos_y;
            default: axis_pos = r_item.pos_z;
        endcase
    end

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL: begin
                mul_a = cicmd_pkg::MUL_A_W'(axis_pos);
                mul_b = r_cpl;
            end
            S_MA: begin
                mul_a = cicmd_pkg::MUL_A_W'(wsel[0]);
                mul_b = cicmd_pkg::MUL_B_W'(wsel[1]);
            end
            S_MB: begin
                mul_a = r_prod[cicmd_pkg::MUL_A_W-1:0];
                mul_b = cicmd_pkg::MUL_B_W'(wsel[2]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = cicmd_pkg::PROD_W'(mul_a) * cicmd_pkg::PROD_W'(mul_b);
    assign g_int   = r_prod[2*cicmd_pkg::FRAC_W +: cicmd_pkg::GINT_W];
    assign w_round = r_prod[cicmd_pkg::W3_W-1:0]
                     + (cicmd_pkg::W3_W'(1) << (2 * cicmd_pkg::FRAC_W - 1));
    assign upd_sum = {1'b0, grid_rdata} + (cicmd_pkg::CELL_W + 1)'(r_weight);
    assign rd_ok   = (32'(r_item.cell_x) < 32'(cicmd_pkg::GRID_SIDE))
                     && (32'(r_item.cell_y) < 32'(cicmd_pkg::GRID_SIDE))
                     && (32'(r_item.cell_z) < 32'(cicmd_pkg::GRID_SIDE));

    always_comb begin
        n_state   = r_state;
        n_cpl     = r_cpl;
        n_use_cic = r_use_cic;
        n_done    = 1'b0;
        n_result  = r_result;
        n_item    = r_item;
        n_axis    = r_axis;
        n_corner  = r_corner;
        n_lo      = r_lo;
        n_frac    = r_frac;
        n_weight  = r_weight;
        n_addr    = r_addr;
        n_sat     = r_sat;

        grid_req       = '0;
        grid_req.addr  = r_addr;
        grid_req.wdata = upd_sum[cicmd_pkg::CELL_W] ? '1 : upd_sum[cicmd_pkg::CELL_W-1:0];

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cicmd_pkg::REG_CELLS_PER_LENGTH:  n_cpl     = i_cfg_wdata;
                cicmd_pkg::REG_USE_CLOUD_IN_CELL: n_use_cic = i_cfg_wdata[0];
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                if (!grid_clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_item   = i_item;
                    n_axis   = '0;
                    n_corner = '0;
                    n_sat    = 1'b0;
                    n_state  = (i_item.opcode == cicmd_pkg::OP_READ) ? S_RREQ : S_MUL;
                end
            end
            S_RREQ: begin
                grid_req.rd_en = 1'b1;
                grid_req.addr  = cicmd_pkg::flat_index(
                                     cicmd_pkg::IDX_W'(r_item.cell_x),
                                     cicmd_pkg::IDX_W'(r_item.cell_y),
                                     cicmd_pkg::IDX_W'(r_item.cell_z));
                n_state = S_RRSP;
            end
            S_RRSP: begin
                n_done              = 1'b1;
                n_result.cell_value = rd_ok ? grid_rdata : '0;
                n_result.out_of_box = 1'b0;
                n_result.saturated  = 1'b0;
                n_result.batch_done = r_item.last_item;
                n_state             = S_IDLE;
            end
            S_MUL: begin
                n_state = S_GRAB;
            end
            S_GRAB: begin
                if (32'(g_int) >= 32'(cicmd_pkg::GRID_SIDE)) begin
                    // outside the box: flag and drop the deposit
                    n_done              = 1'b1;
                    n_result.cell_value = '0;
                    n_result.out_of_box = 1'b1;
                    n_result.saturated  = 1'b0;
                    n_result.batch_done = r_item.last_item;
                    n_state             = S_IDLE;
                end else begin
                    n_lo[r_axis]   = cicmd_pkg::IDX_W'(g_int);
                    n_frac[r_axis] = r_prod[cicmd_pkg::FRAC_W +: cicmd_pkg::FRAC_W];
                    if (r_axis == 2'd2) begin
                        n_state = S_MA;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_MA: begin
                grid_req.rd_en = 1'b1;
                grid_req.addr  = cicmd_pkg::flat_index(csel[0], csel[1], csel[2]);
                n_addr         = grid_req.addr;
                if (r_use_cic) begin
                    n_state = S_MB;
                end else begin
                    n_weight = cicmd_pkg::ONE_FIX;
                    n_state  = S_UPD;
                end
            end
            S_MB: begin
                n_state = S_WT;
            end
            S_WT: begin
                n_weight = w_round[2*cicmd_pkg::FRAC_W +: cicmd_pkg::WGT_W];
                n_state  = S_UPD;
            end
            S_UPD: begin
                grid_req.wr_en = 1'b1;
                n_sat          = r_sat | upd_sum[cicmd_pkg::CELL_W];
                if (!r_use_cic || r_corner == 3'd7) begin
                    n_done              = 1'b1;
                    n_result.cell_value = '0;
                    n_result.out_of_box = 1'b0;
                    n_result.saturated  = r_sat | upd_sum[cicmd_pkg::CELL_W];
                    n_result.batch_done = r_item.last_item;
                    n_state             = S_IDLE;
                end else begin
                    n_corner = r_corner + 3'd1;
                    n_state  = S_MA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cpl     <= cicmd_pkg::CPL_RESET;
            r_use_cic <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cpl     <= n_cpl;
            r_use_cic <= n_use_cic;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_item   <= n_item;
        r_axis   <= n_axis;
        r_corner <= n_corner;
        r_lo     <= n_lo;
        r_frac   <= n_frac;
        r_prod   <= prod;
        r_weight <= n_weight;
        r_addr   <= n_addr;
        r_sat    <= n_sat;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // The strobe lands as the sequencer returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // Only a cell read can return a non-zero density
    a_value_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_result.cell_value != '0)) |-> $past(r_state == S_RRSP))
        else $error("non-zero cell value on a deposit result");

    // Nearest-grid-point mode touches a single cell
    a_ngp_one_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && !r_use_cic) |-> (r_corner == 3'd0))
        else $error("extra corner update in nearest-grid-point mode");

    // Grid writes come only from the update step
    a_write_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grid_req.wr_en |-> (r_state == S_UPD))
        else $error("grid write outside update step");

endmodule
